// ===== src/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg: shared definitions for the sorted list engine
// Sizes, request and status codes, command and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  // table geometry
  localparam int CAPACITY    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int REQ_W       = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_FIND
  } op_t;

  typedef struct packed {
    op_t  op;
    key_t value;
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== src/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// sle_req_if: request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if import sle_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [REQ_W-1:0]      req_type;
  logic signed [IN_VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ===== src/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sle_rsp_if: response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_rsp_if import sle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    position;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    entry_count;

  modport source (output valid, output position, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input position, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/sorted_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_core: sorted insertion table
// Keeps up to CAPACITY signed values in non-decreasing order and serves
// insert, delete-first-match and find-first-match requests.
//
// Channels: req carries req_type and value, rsp carries position, status
// and entry_count; both are valid/ready and move one transaction per edge
// with valid and ready high. Every request yields exactly one response.
// A request passes the command queue, the capture registers and the result
// register. The back end takes one command at a time; its cells compare when
// it is taken and shift when its result is registered.
// A two-entry command queue takes requests while the back end is busy, so
// req stays ready until two commands are waiting.
// When rsp is stalled the result holds in the output register, the back
// end waits with its next command captured, and the queue fills.
// Reset empties the table and the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_core import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // intake and command queue
  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // cell row and result register
  sle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== src/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front: request intake
// Decodes request codes into commands and buffers them in a small queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sle_req_if.sink   req,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;
  cmd_t              decoded;

  // request code to command; the two unused codes read as a find
  always_comb begin
    decoded.value = key_t'(req.value);
    case (req.req_type)
      REQ_INSERT: decoded.op = OP_INSERT;
      REQ_DELETE: decoded.op = OP_DELETE;
      default:    decoded.op = OP_FIND;
    endcase
  end

  assign req.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back: table engine
// Row of compare-and-shift cells: compares are registered as a command is
// taken; then the cells shift and the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  sle_rsp_if.source rsp
);

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  key_t                entries      [CAPACITY];
  key_t                entries_next [CAPACITY];
  op_t                 op_q;
  key_t                value_q;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] ge_q;
  logic [CAPACITY-1:0] eq_q;
  logic [CNT_W-1:0]    at;
  logic                found;
  logic                full;
  logic                take;
  logic                fire;
  logic [POS_W-1:0]    pos_next;
  logic [STATUS_W-1:0] stat_next;
  logic                rsp_valid;
  logic [POS_W-1:0]    rsp_position;
  logic [STATUS_W-1:0] rsp_status;
  logic [POS_W-1:0]    rsp_entry_count;

  // per-cell compare against the incoming value, occupied cells only
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < count) && (entries[i] >= cmd.value);
      eq[i] = (CNT_W'(i) < count) && (entries[i] == cmd.value);
    end
  end

  // control: take a command when idle, finish once the output slot is free
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    take       = 1'b0;
    fire       = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          take       = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!rsp_valid || rsp.ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // first cell at or above the value; the fill count when there is none
  always_comb begin
    at = count;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (ge_q[i]) begin
        at = CNT_W'(i);
      end
    end
  end

  // equal entries are contiguous, so a match sits at the first cell at or above
  assign found = |eq_q;
  assign full  = (count >= CNT_W'(CAPACITY));

  // shift plan and result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
    end
    count_next = count;
    pos_next   = '0;
    stat_next  = STAT_OK;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == at) begin
              entries_next[i] = value_q;
            end
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (CNT_W'(i) > at) begin
              entries_next[i] = entries[i-1];
            end
          end
          count_next = count + 1'b1;
          pos_next   = POS_W'(at + CNT_W'(1));
        end
      end
      OP_DELETE: begin
        if (!found) begin
          stat_next = STAT_NOT_FOUND;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CNT_W'(i) >= at) begin
              entries_next[i] = entries[i+1];
            end
          end
          count_next = count - 1'b1;
          pos_next   = POS_W'(at + CNT_W'(1));
        end
      end
      default: begin
        if (!found) begin
          stat_next = STAT_NOT_FOUND;
        end else begin
          pos_next = POS_W'(at + CNT_W'(1));
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command capture, cell row and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      op_q    <= cmd.op;
      value_q <= cmd.value;
      ge_q    <= ge;
      eq_q    <= eq;
    end
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] <= entries_next[i];
      end
      rsp_position    <= pos_next;
      rsp_status      <= stat_next;
      rsp_entry_count <= POS_W'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.position    = rsp_position;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_entry_count;

endmodule

`default_nettype wire

// ===== src/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker: response checks
// Watches the response port for results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker import sle_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [POS_W-1:0]    rsp_position,
  input wire logic [STATUS_W-1:0] rsp_status,
  input wire logic [POS_W-1:0]    rsp_entry_count
);

  // a refused insert only happens on a full table
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_FULL) |->
      (rsp_position == '0) && (rsp_entry_count == POS_W'(CAPACITY)))
    else $error("full status with bad position or count");

  // a miss reports no position
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_NOT_FOUND) |-> (rsp_position == '0))
    else $error("not-found status with nonzero position");

  // a hit points inside the table as it stood around the request
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_OK) |->
      (rsp_position != '0) &&
      ({1'b0, rsp_position} <= ({1'b0, rsp_entry_count} + (POS_W + 1)'(1))))
    else $error("ok status with position out of range");

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_position) && $stable(rsp_status) &&
      $stable(rsp_entry_count))
    else $error("stalled response changed");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_position    (rsp.position),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
